@@ src/hand_gesture_command_encoder_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Hand gesture command encoder assertion macros
// Concurrent assertion shorthands used by the encoder top level.
// ----------------------------------------------------------------------------
`ifndef HAND_GESTURE_COMMAND_ENCODER_UNIT_MACROS_SVH
`define HAND_GESTURE_COMMAND_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define HGCE_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HGCE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hgce_pkg.sv @@
// ----------------------------------------------------------------------------
// Hand gesture command encoder package
// Shared widths, register indexes, pose codes, pipeline types and the
// arctangent step table of the roll CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

package hgce_pkg;

  localparam int unsigned SAMPLE_W         = 12;
  localparam int unsigned ACCEL_W          = 16;
  localparam int unsigned THRESH_W         = 12;
  localparam int unsigned MODE_W           = 2;
  localparam int unsigned LEVEL_W          = 4;
  localparam int unsigned CHANNELS         = 4;
  localparam int unsigned FLEX_CHANNELS    = 3;
  localparam int unsigned WINDOW_DEPTH_DEF = 4;
  localparam int unsigned ROLL_LEVELS      = 10;

  // ADC channel order within one scan.
  localparam int unsigned CH_BUTTON     = 0;
  localparam int unsigned CH_FLEX_ONE   = 1;
  localparam int unsigned CH_FLEX_TWO   = 2;
  localparam int unsigned CH_FLEX_THREE = 3;

  localparam logic [THRESH_W-1:0] BUTTON_THRESHOLD_RST = 12'd100;
  localparam logic [THRESH_W-1:0] FLEX_THRESHOLD_RST   = 12'd200;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLEX_THRESHOLD   = 1'b1;

  // Roll CORDIC: angles in units of pi/2^17, a quarter turn is 2^16.
  localparam int unsigned MAG_W          = 17;
  localparam int unsigned ANG_W          = MAG_W + 2;
  localparam int unsigned XY_W           = 33;
  localparam int unsigned CORDIC_PRESCALE = 14;
  localparam int unsigned CORDIC_STAGES  = 4;
  localparam int unsigned CORDIC_STEPS   = 4;
  localparam logic [MAG_W-1:0] HALF_PI   = 17'd65536;

  typedef enum logic [1:0] {
    FINGER_UP         = 2'd0,
    FINGER_DOWN       = 2'd1,
    FINGER_HORIZONTAL = 2'd2
  } finger_dir_t;

  typedef enum logic [1:0] {
    FACE_BACK_UP = 2'd0,
    FACE_PALM_UP = 2'd1,
    FACE_EDGE_UP = 2'd2
  } hand_face_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
  } cordic_t;

  typedef struct packed {
    finger_dir_t finger;
    hand_face_t  face;
    logic        y_zero;
    logic        z_zero;
    logic        neg;
  } pose_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [FLEX_CHANNELS-1:0] bent;
    pose_t                    pose;
  } res_t;

  // atan(2^-i) in units of pi/2^17.
  function automatic logic [MAG_W-1:0] arc_step(input logic [3:0] idx);
    logic [MAG_W-1:0] val;
    case (idx)
      4'd0:    val = 17'd32768;
      4'd1:    val = 17'd19344;
      4'd2:    val = 17'd10221;
      4'd3:    val = 17'd5188;
      4'd4:    val = 17'd2604;
      4'd5:    val = 17'd1303;
      4'd6:    val = 17'd652;
      4'd7:    val = 17'd326;
      4'd8:    val = 17'd163;
      4'd9:    val = 17'd81;
      4'd10:   val = 17'd41;
      4'd11:   val = 17'd20;
      4'd12:   val = 17'd10;
      4'd13:   val = 17'd5;
      4'd14:   val = 17'd3;
      default: val = 17'd1;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

@@ src/hgce_window_lane.sv @@
// ----------------------------------------------------------------------------
// Hand gesture encoder window lane
// Circular window of the last scans of one ADC channel with a running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module hgce_window_lane #(
  parameter int unsigned WINDOW_DEPTH = hgce_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    push,
  input  logic [$clog2(WINDOW_DEPTH)-1:0]                         slot,
  input  logic [hgce_pkg::SAMPLE_W-1:0]                           sample,
  output logic [hgce_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0]      sum_nxt
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W  = hgce_pkg::SAMPLE_W + SLOT_W;

  logic [hgce_pkg::SAMPLE_W-1:0] win_r [WINDOW_DEPTH];
  logic [SUM_W-1:0]              sum_r;

  // The oldest sample leaves the sum as the new one enters the same slot.
  assign sum_nxt = sum_r - SUM_W'(win_r[slot]) + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      sum_r <= '0;
    end else if (push) begin
      win_r[slot] <= sample;
      sum_r       <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/hand_gesture_command_encoder_unit.sv @@
// Throughput: one item per cycle while the result is not stalled; a seven-stage pipeline (scan sums,
//   averages and pose, four CORDIC stages of four roll steps each, result register) sets this.
// Stages that hold no item fill while the result is stalled.
// Reset (synchronous, rst_n low) clears the window, sums, baselines, press latch,
//   mode and pipeline, and sets the thresholds to 100 and 200.
// ----------------------------------------------------------------------------
// Hand gesture command encoder
// Averages four ADC channels over a sliding window, tracks a button-driven
// mode, flags bent fingers, classifies hand pose and quantises roll.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hand_gesture_command_encoder_unit_macros.svh"

module hand_gesture_command_encoder_unit #(
  parameter int unsigned WINDOW_DEPTH = hgce_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [hgce_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hgce_pkg::THRESH_W-1:0]         cfg_wdata,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic [hgce_pkg::SAMPLE_W-1:0]         in_button_sample,
  input  logic [hgce_pkg::SAMPLE_W-1:0]         in_flex_one_sample,
  input  logic [hgce_pkg::SAMPLE_W-1:0]         in_flex_two_sample,
  input  logic [hgce_pkg::SAMPLE_W-1:0]         in_flex_three_sample,
  input  logic signed [hgce_pkg::ACCEL_W-1:0]   in_accel_x,
  input  logic signed [hgce_pkg::ACCEL_W-1:0]   in_accel_y,
  input  logic signed [hgce_pkg::ACCEL_W-1:0]   in_accel_z,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [hgce_pkg::MODE_W-1:0]           out_mode,
  output logic                                  out_flex_one_bent,
  output logic                                  out_flex_two_bent,
  output logic                                  out_flex_three_bent,
  output logic [1:0]                            out_finger_direction,
  output logic [1:0]                            out_hand_face,
  output logic                                  out_fingers_up,
  output logic                                  out_palm_up,
  output logic [hgce_pkg::LEVEL_W-1:0]          out_roll_level
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W  = hgce_pkg::SAMPLE_W + SLOT_W;

  // The average is the window sum times a rounded-up reciprocal. With the
  // shift at least the sum width plus log2 of the depth the error term stays
  // below one part in the depth, so the floor is exact for every sum.
  localparam int unsigned RECIP_SHIFT = SUM_W + SLOT_W + 1;
  localparam int unsigned RECIP = ((2 ** RECIP_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam int unsigned PROD_W = SUM_W + RECIP_SHIFT;

  // Pipeline stage numbering.
  localparam int unsigned ST_P1  = 0;
  localparam int unsigned ST_P2  = 1;
  localparam int unsigned ST_C0  = 2;
  localparam int unsigned NSTAGE = 3 + hgce_pkg::CORDIC_STAGES;
  localparam int unsigned ST_OUT = NSTAGE - 1;

  // Roll quantisation: u spans 0 .. 2^17, level = 1 + ((L-1)*u + 2^16) >> 17.
  localparam int unsigned U_W       = hgce_pkg::MAG_W + 1;
  localparam int unsigned LVL_W     = hgce_pkg::LEVEL_W + 1;
  localparam int unsigned LVL_PROD_W = U_W + hgce_pkg::LEVEL_W;

  // --------------------------------------------------------------------------
  // Handshake and pipeline occupancy
  // --------------------------------------------------------------------------
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] v_nxt;
  logic [NSTAGE-1:0] rdy;
  logic              in_accept;
  logic              press_move;

  // A stage can take a new item when it is empty or its item moves on this
  // cycle, so empty stages keep filling behind a stalled result.
  always_comb begin
    rdy[ST_OUT] = !v_r[ST_OUT] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (rdy[ST_P1]) begin
      v_nxt[ST_P1] = in_valid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  assign in_stall   = !rdy[ST_P1];
  assign in_accept  = in_valid && rdy[ST_P1];
  // The press logic and baselines advance when an item leaves the average stage.
  assign press_move = v_r[ST_P2] && rdy[ST_C0];
  assign out_valid  = v_r[ST_OUT];

  // --------------------------------------------------------------------------
  // Configuration registers and per-item state
  // --------------------------------------------------------------------------
  logic [hgce_pkg::THRESH_W-1:0] button_thr_r;
  logic [hgce_pkg::THRESH_W-1:0] flex_thr_r;
  logic [SLOT_W-1:0]             slot_r;
  logic [SLOT_W-1:0]             slot_nxt;
  logic [hgce_pkg::SAMPLE_W-1:0] baseline_r [hgce_pkg::CHANNELS];
  logic [hgce_pkg::SAMPLE_W-1:0] baseline_nxt [hgce_pkg::CHANNELS];
  logic                          press_latch_r;
  logic [hgce_pkg::MODE_W-1:0]   mode_r;
  logic [hgce_pkg::MODE_W-1:0]   mode_nxt;
  logic                          pressed;

  assign slot_nxt = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);

  // --------------------------------------------------------------------------
  // Sliding window: one lane per channel, written in the slot of this transfer
  // --------------------------------------------------------------------------
  logic [hgce_pkg::SAMPLE_W-1:0] samp [hgce_pkg::CHANNELS];
  logic [SUM_W-1:0]              sum_nxt [hgce_pkg::CHANNELS];

  assign samp[hgce_pkg::CH_BUTTON]     = in_button_sample;
  assign samp[hgce_pkg::CH_FLEX_ONE]   = in_flex_one_sample;
  assign samp[hgce_pkg::CH_FLEX_TWO]   = in_flex_two_sample;
  assign samp[hgce_pkg::CH_FLEX_THREE] = in_flex_three_sample;

  for (genvar ch = 0; ch < hgce_pkg::CHANNELS; ch++) begin : g_lane
    hgce_window_lane #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .push    (in_accept),
      .slot    (slot_r),
      .sample  (samp[ch]),
      .sum_nxt (sum_nxt[ch])
    );
  end

  // --------------------------------------------------------------------------
  // Stage P1: window sums including this scan, raw accelerometer reading
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]                  p1_sum_r [hgce_pkg::CHANNELS];
  logic                              p1_cmd_r;
  logic signed [hgce_pkg::ACCEL_W-1:0] p1_x_r;
  logic signed [hgce_pkg::ACCEL_W-1:0] p1_y_r;
  logic signed [hgce_pkg::ACCEL_W-1:0] p1_z_r;

  // --------------------------------------------------------------------------
  // P1 to P2: averages, dominant axis and CORDIC start vector
  // --------------------------------------------------------------------------
  logic [hgce_pkg::SAMPLE_W-1:0] avg_nxt [hgce_pkg::CHANNELS];
  hgce_pkg::pose_t               pose_nxt;
  hgce_pkg::cordic_t             cs_init;

  // Magnitude of a signed reading; the most negative value gives 2^15.
  function automatic logic [hgce_pkg::ACCEL_W:0] mag16(
    input logic signed [hgce_pkg::ACCEL_W-1:0] val
  );
    logic signed [hgce_pkg::ACCEL_W:0] ext;
    ext = {val[hgce_pkg::ACCEL_W-1], val};
    return ext[hgce_pkg::ACCEL_W] ? -ext : ext;
  endfunction

  always_comb begin : b_avg
    logic [PROD_W-1:0] prod;
    for (int ch = 0; ch < hgce_pkg::CHANNELS; ch++) begin
      prod        = PROD_W'(p1_sum_r[ch]) * PROD_W'(RECIP);
      avg_nxt[ch] = prod[RECIP_SHIFT +: hgce_pkg::SAMPLE_W];
    end
  end

  always_comb begin : b_pose
    logic [hgce_pkg::ACCEL_W:0] xa;
    logic [hgce_pkg::ACCEL_W:0] ya;
    logic [hgce_pkg::ACCEL_W:0] za;
    logic [hgce_pkg::ACCEL_W:0] maxa;
    logic                       y_dom;
    logic                       z_dom;
    logic                       y_neg;
    logic                       z_neg;
    xa    = mag16(p1_x_r);
    ya    = mag16(p1_y_r);
    za    = mag16(p1_z_r);
    y_neg = p1_y_r[hgce_pkg::ACCEL_W-1];
    z_neg = p1_z_r[hgce_pkg::ACCEL_W-1];
    // Ties favour x, then y.
    y_dom = ya > xa;
    maxa  = y_dom ? ya : xa;
    z_dom = za > maxa;

    if (!y_dom && !z_dom) begin
      pose_nxt.finger = p1_x_r[hgce_pkg::ACCEL_W-1] ? hgce_pkg::FINGER_UP
                                                    : hgce_pkg::FINGER_DOWN;
    end else begin
      pose_nxt.finger = hgce_pkg::FINGER_HORIZONTAL;
    end
    if (z_dom) begin
      pose_nxt.face = z_neg ? hgce_pkg::FACE_BACK_UP : hgce_pkg::FACE_PALM_UP;
    end else begin
      pose_nxt.face = hgce_pkg::FACE_EDGE_UP;
    end

    pose_nxt.y_zero = (p1_y_r == '0);
    pose_nxt.z_zero = (p1_z_r == '0);
    // Roll is taken as negative in the quadrants where y and z point the same
    // way, with z of zero counted on the negative side of y.
    pose_nxt.neg = (y_neg && (z_neg || pose_nxt.z_zero)) ||
                   (!y_neg && !pose_nxt.y_zero && !z_neg && !pose_nxt.z_zero);

    // Vector (|z|, |y|) scaled up so the shifted terms keep their precision.
    cs_init.x   = hgce_pkg::XY_W'({za, {hgce_pkg::CORDIC_PRESCALE{1'b0}}});
    cs_init.y   = hgce_pkg::XY_W'({ya, {hgce_pkg::CORDIC_PRESCALE{1'b0}}});
    cs_init.ang = '0;
  end

  // --------------------------------------------------------------------------
  // Stage P2: averages, calibrate flag, pose, CORDIC start
  // --------------------------------------------------------------------------
  logic [hgce_pkg::SAMPLE_W-1:0] p2_avg_r [hgce_pkg::CHANNELS];
  logic                          p2_cmd_r;
  hgce_pkg::pose_t               p2_pose_r;

  // Calibrate captures the averages first, so the same item sees no press and
  // no bent finger. A compare is done one bit wider so the sum cannot wrap.
  logic [hgce_pkg::CHANNELS-1:0] exceed;
  hgce_pkg::res_t                res_first;

  always_comb begin : b_press
    logic [hgce_pkg::THRESH_W-1:0] thr;
    for (int ch = 0; ch < hgce_pkg::CHANNELS; ch++) begin
      baseline_nxt[ch] = p2_cmd_r ? p2_avg_r[ch] : baseline_r[ch];
      thr = (ch == hgce_pkg::CH_BUTTON) ? button_thr_r : flex_thr_r;
      exceed[ch] = {1'b0, p2_avg_r[ch]} > ({1'b0, baseline_nxt[ch]} + {1'b0, thr});
    end
    pressed  = exceed[hgce_pkg::CH_BUTTON];
    mode_nxt = (pressed && !press_latch_r) ? mode_r + hgce_pkg::MODE_W'(1) : mode_r;

    res_first.mode = mode_nxt;
    res_first.bent = exceed[hgce_pkg::CH_FLEX_THREE:hgce_pkg::CH_FLEX_ONE];
    res_first.pose = p2_pose_r;
  end

  // --------------------------------------------------------------------------
  // CORDIC stages: each performs four vectoring steps on the roll vector
  // --------------------------------------------------------------------------
  hgce_pkg::cordic_t cs_r    [hgce_pkg::CORDIC_STAGES + 1];
  hgce_pkg::cordic_t cs_nxt  [hgce_pkg::CORDIC_STAGES];
  hgce_pkg::res_t    res_r   [hgce_pkg::CORDIC_STAGES];

  always_comb begin : b_cordic
    hgce_pkg::cordic_t           s;
    logic signed [hgce_pkg::XY_W-1:0]  dx;
    logic signed [hgce_pkg::XY_W-1:0]  dy;
    logic signed [hgce_pkg::ANG_W-1:0] da;
    for (int g = 0; g < hgce_pkg::CORDIC_STAGES; g++) begin
      s = cs_r[g];
      for (int j = 0; j < hgce_pkg::CORDIC_STEPS; j++) begin
        // Arithmetic shifts floor negative values, as the rotation requires.
        dx = $signed(s.y) >>> (g * hgce_pkg::CORDIC_STEPS + j);
        dy = $signed(s.x) >>> (g * hgce_pkg::CORDIC_STEPS + j);
        da = $signed({2'b00,
                      hgce_pkg::arc_step(4'(g * hgce_pkg::CORDIC_STEPS + j))});
        if (!s.y[hgce_pkg::XY_W-1]) begin
          s.x   = s.x + dx;
          s.y   = s.y - dy;
          s.ang = s.ang + da;
        end else begin
          s.x   = s.x - dx;
          s.y   = s.y + dy;
          s.ang = s.ang - da;
        end
      end
      cs_nxt[g] = s;
    end
  end

  // --------------------------------------------------------------------------
  // Last CORDIC stage to result: clamp, exact cases, quantise
  // --------------------------------------------------------------------------
  logic [LVL_W-1:0] level_nxt;

  always_comb begin : b_level
    hgce_pkg::cordic_t         fin;
    hgce_pkg::pose_t           fp;
    logic [hgce_pkg::MAG_W-1:0] mag;
    logic [U_W-1:0]            u;
    logic [LVL_PROD_W-1:0]     scaled;
    logic [LVL_W-1:0]          lvl;
    fin = cs_r[hgce_pkg::CORDIC_STAGES];
    fp  = res_r[hgce_pkg::CORDIC_STAGES-1].pose;

    if (fin.ang[hgce_pkg::ANG_W-1]) begin
      mag = '0;
    end else if (fin.ang > $signed({2'b00, hgce_pkg::HALF_PI})) begin
      mag = hgce_pkg::HALF_PI;
    end else begin
      mag = fin.ang[hgce_pkg::MAG_W-1:0];
    end
    // No sideways component means no roll; no vertical one means a full
    // quarter turn.
    if (fp.y_zero) begin
      mag = '0;
    end else if (fp.z_zero) begin
      mag = hgce_pkg::HALF_PI;
    end

    u = fp.neg ? U_W'(hgce_pkg::HALF_PI) - U_W'(mag)
               : U_W'(hgce_pkg::HALF_PI) + U_W'(mag);
    scaled = LVL_PROD_W'(hgce_pkg::ROLL_LEVELS - 1) * LVL_PROD_W'(u)
           + LVL_PROD_W'(hgce_pkg::HALF_PI);
    lvl = LVL_W'(scaled[LVL_PROD_W-1:U_W-1]) + LVL_W'(1);
    level_nxt = (lvl > LVL_W'(hgce_pkg::ROLL_LEVELS)) ? LVL_W'(hgce_pkg::ROLL_LEVELS)
                                                      : lvl;
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  hgce_pkg::res_t   out_res_r;
  logic [LVL_W-1:0] out_level_r;

  // --------------------------------------------------------------------------
  // Control and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r           <= '0;
      slot_r        <= '0;
      button_thr_r  <= hgce_pkg::BUTTON_THRESHOLD_RST;
      flex_thr_r    <= hgce_pkg::FLEX_THRESHOLD_RST;
      press_latch_r <= 1'b0;
      mode_r        <= '0;
      for (int ch = 0; ch < hgce_pkg::CHANNELS; ch++) begin
        baseline_r[ch] <= '0;
      end
    end else begin
      v_r <= v_nxt;
      if (in_accept) begin
        slot_r <= slot_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          hgce_pkg::CFG_BUTTON_THRESHOLD: button_thr_r <= cfg_wdata;
          hgce_pkg::CFG_FLEX_THRESHOLD:   flex_thr_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (press_move) begin
        // The latch follows the press state: set while held, clear on release.
        press_latch_r <= pressed;
        mode_r        <= mode_nxt;
        for (int ch = 0; ch < hgce_pkg::CHANNELS; ch++) begin
          baseline_r[ch] <= baseline_nxt[ch];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rdy[ST_P1]) begin
      for (int ch = 0; ch < hgce_pkg::CHANNELS; ch++) begin
        p1_sum_r[ch] <= sum_nxt[ch];
      end
      p1_cmd_r <= in_cmd;
      p1_x_r   <= in_accel_x;
      p1_y_r   <= in_accel_y;
      p1_z_r   <= in_accel_z;
    end
    if (rdy[ST_P2]) begin
      for (int ch = 0; ch < hgce_pkg::CHANNELS; ch++) begin
        p2_avg_r[ch] <= avg_nxt[ch];
      end
      p2_cmd_r  <= p1_cmd_r;
      p2_pose_r <= pose_nxt;
      cs_r[0]   <= cs_init;
    end
    for (int g = 0; g < hgce_pkg::CORDIC_STAGES; g++) begin
      if (rdy[ST_C0 + g]) begin
        cs_r[g+1] <= cs_nxt[g];
      end
    end
    if (rdy[ST_C0]) begin
      res_r[0] <= res_first;
    end
    for (int g = 1; g < hgce_pkg::CORDIC_STAGES; g++) begin
      if (rdy[ST_C0 + g]) begin
        res_r[g] <= res_r[g-1];
      end
    end
    if (rdy[ST_OUT]) begin
      out_res_r   <= res_r[hgce_pkg::CORDIC_STAGES-1];
      out_level_r <= level_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result ports
  // --------------------------------------------------------------------------
  assign out_mode             = out_res_r.mode;
  assign out_flex_one_bent    = out_res_r.bent[hgce_pkg::CH_FLEX_ONE - 1];
  assign out_flex_two_bent    = out_res_r.bent[hgce_pkg::CH_FLEX_TWO - 1];
  assign out_flex_three_bent  = out_res_r.bent[hgce_pkg::CH_FLEX_THREE - 1];
  assign out_finger_direction = out_res_r.pose.finger;
  assign out_hand_face        = out_res_r.pose.face;
  assign out_fingers_up       = (out_res_r.pose.finger == hgce_pkg::FINGER_UP);
  assign out_palm_up          = (out_res_r.pose.face == hgce_pkg::FACE_PALM_UP);
  assign out_roll_level       = out_level_r[hgce_pkg::LEVEL_W-1:0];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The window slot moves only with an input transfer.
  `HGCE_ASSERT_NEXT(a_slot_hold, clk, rst_n, !in_accept, $stable(slot_r), "window slot moved without an input transfer")
  // The mode changes only when an item passes the press logic.
  `HGCE_ASSERT_NEXT(a_mode_hold, clk, rst_n, !press_move, $stable(mode_r), "mode changed with no item at the press stage")
  // Input is refused only when every stage is full and the result is stalled.
  `HGCE_ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall, (&v_r) && out_stall, "input stalled while the pipeline had room")

endmodule

`default_nettype wire
